// ===== hw/rtl/vqh_pkg.sv =====
// Shared types and constants of the nearest-codeword histogram block.
`default_nettype none

package vqh_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_CB_WRITE = 2'd0;
  localparam logic [1:0] REQ_DESC     = 2'd1;
  localparam logic [1:0] REQ_BIN_READ = 2'd2;
  localparam logic [1:0] REQ_CLEAR    = 2'd3;

  // Result kinds carried in result_kind.
  localparam logic KIND_NEAREST = 1'b0;
  localparam logic KIND_BIN     = 1'b1;

  // Configuration register indexes and port widths.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_CENTERS   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VECTOR_LENGTH = 2'd1;

  // Distance accumulator width and its saturation value.
  localparam int DIST_BITS = 39;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 39'h7F_FFFF_FFFF;

  // Squares of magnitudes at or above 2^SQ_BITS saturate the distance.
  localparam int SQ_BITS = 20;

  // Control that travels with each beat through the distance unit.
  typedef struct packed {
    logic start;        // first beat of a search
    logic first_elem;   // first element of a center
    logic last_elem;    // last element of a center
    logic last_center;  // last element of the last center
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vqh_in_if.sv =====
// Input request channel of the nearest-codeword histogram block.
`default_nettype none

interface vqh_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         center_index;
  logic [6:0]         element_index;
  logic signed [15:0] value;
  logic               last_element;

  modport source (
    output valid, req_type, center_index, element_index, value, last_element,
    input  ready
  );
  modport sink (
    input  valid, req_type, center_index, element_index, value, last_element,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/vqh_out_if.sv =====
// Result channel of the nearest-codeword histogram block.
`default_nettype none

interface vqh_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  nearest_center;
  logic [38:0] best_distance;
  logic [15:0] bin_count;

  modport source (
    output valid, result_kind, nearest_center, best_distance, bin_count,
    input  ready
  );
  modport sink (
    input  valid, result_kind, nearest_center, best_distance, bin_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/vqh_cfg_if.sv =====
// Configuration write channel of the nearest-codeword histogram block.
`default_nettype none

interface vqh_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [vqh_pkg::CFG_INDEX_BITS-1:0] index;
  logic [vqh_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nearest_codeword_histogram_top.sv =====
// Top level of the nearest-codeword histogram block: sequencer, stores and result register.
//
//   Channel  Modport  Carries
//   -------  -------  ----------------------------------------------------------------
//   req      sink     req_type, center_index, element_index, value, last_element
//   rsp      source   result_kind, nearest_center, best_distance, bin_count
//   cfg      sink     index (0 num_centers, 1 vector_length), data
//
// Codebook writes, descriptor elements that are not last and bin reads take one beat
// each; after a bin read the block passes its read and result states before it is ready
// again. A last descriptor element starts the search: the single
// subtract-square-accumulate unit visits every element of every center once, then the
// pipeline drains and the histogram bin of the nearest center is updated.
// After reset and after every clear request the block sweeps the histogram one bin per
// cycle and takes no request meanwhile; configuration is always taken. A result waits in
// the output register while rsp stalls; the block takes new requests meanwhile and only
// holds its next result until that register is free.
`default_nettype none

module nearest_codeword_histogram_top #(
  parameter int MAX_CENTERS  = 256,
  parameter int MAX_DIM      = 128,
  parameter int ELEMENT_BITS = 16,
  parameter int COUNT_BITS   = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  vqh_in_if.sink      req,
  vqh_out_if.source   rsp,
  vqh_cfg_if.sink     cfg
);

  localparam int CW      = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int DW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CbDepth = MAX_CENTERS * (2 ** DW);
  localparam int CntW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_HUPD   = 3'd4;
  localparam logic [2:0] ST_BREAD  = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  // Clip a stored count to the 16-bit result field.
  function automatic logic [15:0] clip16(input logic [COUNT_BITS-1:0] v);
    logic [CntW-1:0] w;
    w = CntW'(v);
    return (w > CntW'(32'h0000_FFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  logic [2:0]                    state;
  logic [8:0]                    num_centers;
  logic [7:0]                    vector_length;
  logic [31:0]                   nc_eff;
  logic [31:0]                   vl_eff;
  logic                          acc_in;
  logic                          ci_ok;
  logic                          ei_ok;
  logic signed [ELEMENT_BITS-1:0] elem_in;

  logic [CW-1:0]                 cen;
  logic [DW-1:0]                 ele;
  logic [CW-1:0]                 c_last;
  logic [DW-1:0]                 e_last;
  logic [CW-1:0]                 clr_idx;
  logic                          issue;
  logic                          iss_v;
  vqh_pkg::mac_ctl_t             iss_ctl_d;
  vqh_pkg::mac_ctl_t             iss_ctl;

  logic signed [ELEMENT_BITS-1:0] cb_mem [CbDepth];
  logic signed [ELEMENT_BITS-1:0] desc_mem [MAX_DIM];
  logic [COUNT_BITS-1:0]          hist_mem [MAX_CENTERS];
  logic signed [ELEMENT_BITS-1:0] cb_rd;
  logic signed [ELEMENT_BITS-1:0] desc_rd;
  logic                           cb_we;
  logic                           desc_we;
  logic [CW+DW-1:0]               cb_waddr;
  logic [CW+DW-1:0]               cb_raddr;

  logic                          hist_we;
  logic                          hist_re;
  logic [CW-1:0]                 hist_waddr;
  logic [CW-1:0]                 hist_raddr;
  logic [COUNT_BITS-1:0]         hist_wdata;
  logic [COUNT_BITS-1:0]         hist_rd;
  logic [COUNT_BITS-1:0]         cnt_inc;

  logic                          mac_done;
  logic [vqh_pkg::DIST_BITS-1:0] best_dist;
  logic [CW-1:0]                 best_idx;

  logic [7:0]                    bq_idx;
  logic                          bq_ok;
  logic                          res_kind;
  logic [7:0]                    res_center;
  logic [vqh_pkg::DIST_BITS-1:0] res_dist;
  logic [15:0]                   res_count;
  logic                          out_v;
  logic                          out_load;
  logic                          o_kind;
  logic [7:0]                    o_center;
  logic [vqh_pkg::DIST_BITS-1:0] o_dist;
  logic [15:0]                   o_count;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_centers   <= 9'd256;
      vector_length <= 8'd128;
    end else if (cfg.valid) begin
      case (cfg.index)
        vqh_pkg::REG_NUM_CENTERS:   num_centers   <= cfg.data[8:0];
        vqh_pkg::REG_VECTOR_LENGTH: vector_length <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // A zero register acts as one, and a value above the store size acts as the size.
  always_comb begin
    nc_eff = 32'(num_centers);
    if (nc_eff == 32'd0) begin
      nc_eff = 32'd1;
    end else if (nc_eff > 32'(MAX_CENTERS)) begin
      nc_eff = 32'(MAX_CENTERS);
    end
    vl_eff = 32'(vector_length);
    if (vl_eff == 32'd0) begin
      vl_eff = 32'd1;
    end else if (vl_eff > 32'(MAX_DIM)) begin
      vl_eff = 32'(MAX_DIM);
    end
  end

  // Request decode. Requests are taken only while the sequencer is idle.
  assign req.ready = (state == ST_IDLE);
  assign acc_in    = req.valid && req.ready;
  assign ci_ok     = 32'(req.center_index) < 32'(MAX_CENTERS);
  assign ei_ok     = 32'(req.element_index) < 32'(MAX_DIM);
  assign elem_in   = ELEMENT_BITS'(req.value);
  assign cb_we     = acc_in && (req.req_type == vqh_pkg::REQ_CB_WRITE) && ci_ok && ei_ok;
  assign desc_we   = acc_in && (req.req_type == vqh_pkg::REQ_DESC) && ei_ok;

  // Search scan: one element of one center per cycle.
  assign issue     = (state == ST_SEARCH);
  assign cb_waddr  = {CW'(req.center_index), DW'(req.element_index)};
  assign cb_raddr  = {cen, ele};

  always_comb begin
    iss_ctl_d.first_elem  = (ele == '0);
    iss_ctl_d.last_elem   = (ele == e_last);
    iss_ctl_d.last_center = (ele == e_last) && (cen == c_last);
    iss_ctl_d.start       = (ele == '0) && (cen == '0);
  end

  // Codebook and descriptor stores, both read with a registered port.
  always_ff @(posedge clk) begin
    if (cb_we) begin
      cb_mem[cb_waddr] <= elem_in;
    end
    if (issue) begin
      cb_rd <= cb_mem[cb_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[DW'(req.element_index)] <= elem_in;
    end
    if (issue) begin
      desc_rd <= desc_mem[ele];
    end
    iss_ctl <= iss_ctl_d;
  end

  vqh_dist_unit #(
    .ELEMENT_BITS (ELEMENT_BITS),
    .CENTER_BITS  (CW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (iss_v),
    .in_ctl    (iss_ctl),
    .desc_elem (desc_rd),
    .cb_elem   (cb_rd),
    .done      (mac_done),
    .best_dist (best_dist),
    .best_idx  (best_idx)
  );

  // Histogram store: cleared by a sweep, read for bin reads and for the increment.
  assign cnt_inc = (hist_rd == {COUNT_BITS{1'b1}}) ? hist_rd : hist_rd + 1'b1;

  always_comb begin
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    hist_waddr = clr_idx;
    hist_wdata = '0;
    hist_raddr = CW'(req.center_index);
    case (state)
      ST_CLEAR: hist_we = 1'b1;
      ST_IDLE:  hist_re = acc_in && (req.req_type == vqh_pkg::REQ_BIN_READ);
      ST_DRAIN: begin
        hist_re    = mac_done;
        hist_raddr = best_idx;
      end
      ST_HUPD: begin
        hist_we    = 1'b1;
        hist_waddr = best_idx;
        hist_wdata = cnt_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rd <= hist_mem[hist_raddr];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      cen     <= '0;
      ele     <= '0;
      c_last  <= '0;
      e_last  <= '0;
      iss_v   <= 1'b0;
    end else begin
      iss_v <= issue;
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CW'(MAX_CENTERS - 1)) begin
            clr_idx <= '0;
            state   <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc_in) begin
            case (req.req_type)
              vqh_pkg::REQ_DESC: begin
                if (req.last_element) begin
                  cen    <= '0;
                  ele    <= '0;
                  c_last <= CW'(nc_eff - 32'd1);
                  e_last <= DW'(vl_eff - 32'd1);
                  state  <= ST_SEARCH;
                end
              end
              vqh_pkg::REQ_BIN_READ: state <= ST_BREAD;
              vqh_pkg::REQ_CLEAR: begin
                clr_idx <= '0;
                state   <= ST_CLEAR;
              end
              default: ;
            endcase
          end
        end
        ST_SEARCH: begin
          if (ele == e_last) begin
            ele <= '0;
            cen <= cen + 1'b1;
            if (cen == c_last) begin
              state <= ST_DRAIN;
            end
          end else begin
            ele <= ele + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            state <= ST_HUPD;
          end
        end
        ST_HUPD:  state <= ST_RESULT;
        ST_BREAD: state <= ST_RESULT;
        ST_RESULT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result staging. A bin read outside the store reports a zero count.
  always_ff @(posedge clk) begin
    if (acc_in && (req.req_type == vqh_pkg::REQ_BIN_READ)) begin
      bq_idx <= req.center_index;
      bq_ok  <= ci_ok;
    end
    if (state == ST_BREAD) begin
      res_kind   <= vqh_pkg::KIND_BIN;
      res_center <= bq_idx;
      res_dist   <= '0;
      res_count  <= bq_ok ? clip16(hist_rd) : 16'd0;
    end
    if (state == ST_HUPD) begin
      res_kind   <= vqh_pkg::KIND_NEAREST;
      res_center <= 8'(best_idx);
      res_dist   <= best_dist;
      res_count  <= clip16(cnt_inc);
    end
  end

  // Output register: loads when empty or when its beat is taken in the same cycle.
  assign out_load = (state == ST_RESULT) && (!out_v || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_load) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_kind   <= res_kind;
      o_center <= res_center;
      o_dist   <= res_dist;
      o_count  <= res_count;
    end
  end

  assign rsp.valid          = out_v;
  assign rsp.result_kind    = o_kind;
  assign rsp.nearest_center = o_center;
  assign rsp.best_distance  = o_dist;
  assign rsp.bin_count      = o_count;

endmodule

`default_nettype wire

// ===== hw/rtl/vqh_dist_unit.sv =====
// Shared subtract, square and accumulate unit with running best-center tracking.
`default_nettype none

module vqh_dist_unit #(
  parameter int ELEMENT_BITS = 16,
  parameter int CENTER_BITS  = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire vqh_pkg::mac_ctl_t                in_ctl,
  input  wire logic signed [ELEMENT_BITS-1:0]   desc_elem,
  input  wire logic signed [ELEMENT_BITS-1:0]   cb_elem,
  output logic                                  done,
  output logic [vqh_pkg::DIST_BITS-1:0]         best_dist,
  output logic [CENTER_BITS-1:0]                best_idx
);

  localparam int MagW = (ELEMENT_BITS + 1 > vqh_pkg::SQ_BITS + 1) ?
                        ELEMENT_BITS + 1 : vqh_pkg::SQ_BITS + 1;

  logic signed [ELEMENT_BITS:0]   diff;
  logic [ELEMENT_BITS:0]          mag;
  logic [ELEMENT_BITS:0]          mag1;
  logic [MagW-1:0]                mag_w;
  logic [vqh_pkg::SQ_BITS-1:0]    m20;
  logic [2*vqh_pkg::SQ_BITS-1:0]  prod;
  logic [2*vqh_pkg::SQ_BITS-1:0]  sq2;
  logic                           sat2;
  logic                           v1;
  logic                           v2;
  vqh_pkg::mac_ctl_t              ctl1;
  vqh_pkg::mac_ctl_t              ctl2;
  logic [vqh_pkg::DIST_BITS-1:0]  acc;
  logic [vqh_pkg::DIST_BITS-1:0]  acc_base;
  logic [2*vqh_pkg::SQ_BITS-1:0]  term;
  logic [vqh_pkg::DIST_BITS+1:0]  sum;
  logic [vqh_pkg::DIST_BITS-1:0]  acc_next;
  logic [CENTER_BITS-1:0]         cur;
  logic [CENTER_BITS-1:0]         center_now;

  // Stage one: difference and magnitude.
  assign diff = {desc_elem[ELEMENT_BITS-1], desc_elem} - {cb_elem[ELEMENT_BITS-1], cb_elem};
  assign mag  = diff[ELEMENT_BITS] ? (ELEMENT_BITS + 1)'(0) - diff : diff;

  // Stage two: square of the low magnitude bits, with an overflow flag.
  assign mag_w = MagW'(mag1);
  assign m20   = mag_w[vqh_pkg::SQ_BITS-1:0];
  assign prod  = m20 * m20;

  // Stage three: saturating accumulate.
  assign acc_base   = ctl2.first_elem ? '0 : acc;
  assign term       = sat2 ? {1'b0, vqh_pkg::DIST_MAX} : sq2;
  assign sum        = {2'b00, acc_base} + {1'b0, term};
  assign acc_next   = (sum > {2'b00, vqh_pkg::DIST_MAX}) ? vqh_pkg::DIST_MAX :
                      sum[vqh_pkg::DIST_BITS-1:0];
  assign center_now = ctl2.start ? '0 : cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      done <= v2 && ctl2.last_center;
    end
  end

  always_ff @(posedge clk) begin
    mag1 <= mag;
    ctl1 <= in_ctl;
    sq2  <= prod;
    sat2 <= (mag_w[MagW-1:vqh_pkg::SQ_BITS] != '0);
    ctl2 <= ctl1;
    if (v2) begin
      acc <= acc_next;
      if (ctl2.last_elem) begin
        cur <= center_now + 1'b1;
        // Strict less-than keeps the lower index on ties.
        if (center_now == '0 || acc_next < best_dist) begin
          best_dist <= acc_next;
          best_idx  <= center_now;
        end
      end else if (ctl2.start) begin
        cur <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/nearest_codeword_checker.sv =====
// Checker that watches the block's channels, predicts every result beat and compares it.
`timescale 1ns / 100ps

module nearest_codeword_checker #(
  parameter int MAX_CENTERS  = 256,
  parameter int MAX_DIM      = 128
) (
  input  logic clk,
  input  logic rst,
  vqh_in_if    req,
  vqh_out_if   rsp,
  vqh_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic                          kind;
    logic [7:0]                    center;
    logic [vqh_pkg::DIST_BITS-1:0] distance;
    logic [15:0]                   count;
  } answer_t;

  logic signed [15:0] codebook_copy [MAX_CENTERS][MAX_DIM];
  logic signed [15:0] descriptor_copy [MAX_DIM];
  logic [15:0]        bin_counts [MAX_CENTERS];
  logic [8:0]         centers_reg;
  logic [7:0]         length_reg;
  answer_t            queued_answers [$];
  int                 faults = 0;
  int                 waiting = 0;

  assign mismatches  = faults;
  assign outstanding = waiting;

  function automatic int clamp_setting(int raw, int hi);
    if (raw == 0) return 1;
    return (raw > hi) ? hi : raw;
  endfunction

  // Exhaustive search in center order; a later center wins only when strictly closer.
  function automatic answer_t nearest_center_search();
    answer_t                       found;
    int                            n, len, c, e;
    longint                        diff;
    logic [63:0]                   mag, total;
    logic [vqh_pkg::DIST_BITS-1:0] acc;
    n     = clamp_setting(int'(centers_reg), MAX_CENTERS);
    len   = clamp_setting(int'(length_reg), MAX_DIM);
    found = '0;
    found.kind = vqh_pkg::KIND_NEAREST;
    for (c = 0; c < n; c++) begin
      acc = '0;
      for (e = 0; e < len; e++) begin
        diff = longint'(descriptor_copy[e]) - longint'(codebook_copy[c][e]);
        mag  = 64'((diff < 0) ? -diff : diff);
        if (mag >= (64'd1 << vqh_pkg::SQ_BITS)) total = 64'(vqh_pkg::DIST_MAX);
        else total = 64'(acc) + mag * mag;
        acc = (total > 64'(vqh_pkg::DIST_MAX)) ? vqh_pkg::DIST_MAX :
              total[vqh_pkg::DIST_BITS-1:0];
      end
      if (c == 0 || acc < found.distance) begin
        found.distance = acc;
        found.center   = 8'(c);
      end
    end
    return found;
  endfunction

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      faults++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    answer_t best;
    if (rst) begin
      foreach (bin_counts[i]) bin_counts[i] = '0;
      centers_reg = 9'd256;
      length_reg  = 8'd128;
      queued_answers.delete();
      waiting <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          vqh_pkg::REG_NUM_CENTERS:   centers_reg = cfg.data[8:0];
          vqh_pkg::REG_VECTOR_LENGTH: length_reg  = cfg.data[7:0];
          default: ;
        endcase
      end

      // Results leave before any request of this edge can add one.
      if (rsp.valid && rsp.ready) begin
        if (queued_answers.size() == 0) begin
          faults++;
          $error("result beat with nothing awaited: kind %0d center %0d count %0d",
                 rsp.result_kind, rsp.nearest_center, rsp.bin_count);
        end else begin
          want = queued_answers.pop_front();
          compare_field("result_kind", want.kind, rsp.result_kind);
          compare_field("nearest_center", want.center, rsp.nearest_center);
          compare_field("best_distance", want.distance, rsp.best_distance);
          compare_field("bin_count", want.count, rsp.bin_count);
        end
      end

      if (req.valid && req.ready) begin
        case (req.req_type)
          vqh_pkg::REQ_CB_WRITE:
            codebook_copy[req.center_index][req.element_index] = req.value;
          vqh_pkg::REQ_DESC: begin
            descriptor_copy[req.element_index] = req.value;
            if (req.last_element) begin
              best = nearest_center_search();
              if (bin_counts[best.center] != 16'hFFFF) bin_counts[best.center]++;
              best.count = bin_counts[best.center];
              queued_answers.push_back(best);
            end
          end
          vqh_pkg::REQ_BIN_READ: begin
            want          = '0;
            want.kind     = vqh_pkg::KIND_BIN;
            want.center   = req.center_index;
            want.count    = bin_counts[req.center_index];
            queued_answers.push_back(want);
          end
          vqh_pkg::REQ_CLEAR: foreach (bin_counts[i]) bin_counts[i] = '0;
          default: ;
        endcase
      end
      waiting <= queued_answers.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench top: drives requests, register writes and result back-pressure, and gives the verdict.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_CENTERS = 256;
  localparam int MAX_DIM     = 128;

  // The watchdog allows several times the length of a full-size search, 256 centers of 128 elements.
  localparam int STALL_LIMIT = 100000;

  // After the last result the block may still be sweeping the histogram after a clear,
  // one bin per cycle.
  localparam int SETTLE_CYCLES = MAX_CENTERS + 64;

  localparam int RANDOM_PHASES = 10;
  localparam int RANDOM_BEATS  = 450;

  // An index with no register behind it; writes to it must change nothing.
  localparam logic [vqh_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  logic clk;
  logic rst;
  logic calm = 1'b0;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles = 0;
  int   beats_sent = 0;
  int   active_centers = MAX_CENTERS;
  int   active_length = MAX_DIM;

  // Stimulus bookkeeping: which store entries hold a value, so that no search
  // ever reads an entry that was never written, and what the codebook holds,
  // so that descriptors can be aimed near a center or copied onto another.
  logic signed [15:0] cb_shadow [MAX_CENTERS][MAX_DIM];
  logic               cb_written [MAX_CENTERS][MAX_DIM];
  logic               desc_written [MAX_DIM];

  vqh_in_if  req ();
  vqh_out_if rsp ();
  vqh_cfg_if cfg ();

  nearest_codeword_histogram_top #(
    .MAX_CENTERS  (MAX_CENTERS),
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (16),
    .COUNT_BITS   (16)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  nearest_codeword_checker #(
    .MAX_CENTERS (MAX_CENTERS),
    .MAX_DIM     (MAX_DIM)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls in about a third of the cycles, except while calm is set.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  // The watchdog counts cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp_setting(int raw, int hi);
    if (raw == 0) return 1;
    return (raw > hi) ? hi : raw;
  endfunction

  // Element values lean toward the two extremes and toward small numbers.
  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // True when every element the search reads is written, counting skip as written.
  function automatic logic descriptor_complete(int skip);
    int e;
    for (e = 0; e < active_length; e++)
      if (!desc_written[e] && e != skip) return 1'b0;
    return 1'b1;
  endfunction

  // Sends one request beat. Valid is left high on return so the next beat can
  // follow back to back; an idle gap or drain() lowers it.
  task automatic send(input logic [1:0] kind, input logic [7:0] ci, input logic [6:0] ei,
                      input logic signed [15:0] val, input logic last);
    while (!calm && $urandom_range(99) < 32) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.req_type      <= kind;
    req.center_index  <= ci;
    req.element_index <= ei;
    req.value         <= val;
    req.last_element  <= last;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    beats_sent++;
    if (kind == vqh_pkg::REQ_CB_WRITE) begin
      cb_shadow[ci][ei]  = val;
      cb_written[ci][ei] = 1'b1;
    end else if (kind == vqh_pkg::REQ_DESC) begin
      desc_written[ei] = 1'b1;
    end
  endtask

  task automatic write_reg(input logic [vqh_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [vqh_pkg::CFG_DATA_BITS-1:0] data);
    if (!calm) repeat ($urandom_range(3)) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every awaited result has come back and the block has gone quiet.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only while the block is idle. The upper data bits are
  // free to carry noise since only the low bits of each register are kept.
  task automatic set_config(input logic [15:0] centers_word, input logic [15:0] length_word);
    drain();
    write_reg(vqh_pkg::REG_NUM_CENTERS, centers_word);
    write_reg(vqh_pkg::REG_VECTOR_LENGTH, length_word);
    active_centers = clamp_setting(int'(centers_word[8:0]), MAX_CENTERS);
    active_length  = clamp_setting(int'(length_word[7:0]), MAX_DIM);
  endtask

  // Writes every codebook entry in the searched range that has no value yet.
  task automatic fill_codebook();
    int c, e;
    for (c = 0; c < active_centers; c++)
      for (e = 0; e < active_length; e++)
        if (!cb_written[c][e])
          send(vqh_pkg::REQ_CB_WRITE, 8'(c), 7'(e), rand_value(), 1'($urandom));
  endtask

  // Duplicates one center onto another so that searches meet exact ties.
  task automatic copy_center();
    int src, dst, e;
    src = $urandom_range(active_centers - 1);
    dst = $urandom_range(active_centers - 1);
    for (e = 0; e < active_length; e++)
      send(vqh_pkg::REQ_CB_WRITE, 8'(dst), 7'(e), cb_shadow[src][e], 1'($urandom));
  endtask

  // A well-formed descriptor: every element once, in order or shuffled, with the
  // last mark on the final beat. The content is random, an exact copy of a
  // center, or a center with small offsets.
  task automatic send_descriptor();
    int                 order [MAX_DIM];
    int                 i, pick, tmp, base, mode;
    logic signed [15:0] v;
    base = $urandom_range(active_centers - 1);
    mode = $urandom_range(3);
    for (i = 0; i < active_length; i++) order[i] = i;
    if ($urandom_range(1)) begin
      for (i = active_length - 1; i > 0; i--) begin
        pick        = $urandom_range(i);
        tmp         = order[i];
        order[i]    = order[pick];
        order[pick] = tmp;
      end
    end
    for (i = 0; i < active_length; i++) begin
      case (mode)
        0:       v = rand_value();
        1:       v = cb_shadow[base][order[i]];
        default: v = cb_shadow[base][order[i]] + 16'(int'($urandom_range(8)) - 4);
      endcase
      send(vqh_pkg::REQ_DESC, 8'($urandom), 7'(order[i]), v, i == active_length - 1);
    end
  endtask

  // Broken traffic: stray descriptor elements anywhere in the buffer, a last
  // mark on an arbitrary element, and codebook writes anywhere, also outside the searched range.
  task automatic send_noise();
    logic [6:0] ei;
    logic       last;
    ei = 7'($urandom);
    if ($urandom_range(1)) begin
      last = ($urandom_range(1) == 1) && descriptor_complete(int'(ei));
      send(vqh_pkg::REQ_DESC, 8'($urandom), ei, rand_value(), last);
    end else begin
      send(vqh_pkg::REQ_CB_WRITE, 8'($urandom), ei, rand_value(), 1'($urandom));
    end
  endtask

  initial begin
    int phase, goal, roll, nc, vl, start;

    req.valid         = 1'b0;
    req.req_type      = vqh_pkg::REQ_CB_WRITE;
    req.center_index  = '0;
    req.element_index = '0;
    req.value         = '0;
    req.last_element  = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = vqh_pkg::REG_NUM_CENTERS;
    cfg.data          = '0;
    foreach (cb_written[i, j]) cb_written[i][j] = 1'b0;
    foreach (desc_written[i]) desc_written[i] = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Three centers of two elements: center 0 sits at the
    // extremes, centers 1 and 2 are equal so a zero descriptor ties between
    // them and must pick center 1. The bins start at zero after reset.
    set_config(16'd3, 16'd2);
    write_reg(REG_SPARE, 16'hFFFF);
    send(vqh_pkg::REQ_BIN_READ, 8'd0, 7'd0, 16'sd0, 1'b0);
    send(vqh_pkg::REQ_BIN_READ, 8'd255, 7'd127, 16'sh7FFF, 1'b1);
    send(vqh_pkg::REQ_CB_WRITE, 8'd0, 7'd0, 16'sh7FFF, 1'b0);
    send(vqh_pkg::REQ_CB_WRITE, 8'd0, 7'd1, 16'sh8000, 1'b1);
    send(vqh_pkg::REQ_CB_WRITE, 8'd1, 7'd0, 16'sd0, 1'b0);
    send(vqh_pkg::REQ_CB_WRITE, 8'd1, 7'd1, 16'sd0, 1'b0);
    send(vqh_pkg::REQ_CB_WRITE, 8'd2, 7'd0, 16'sd0, 1'b0);
    send(vqh_pkg::REQ_CB_WRITE, 8'd2, 7'd1, 16'sd0, 1'b0);
    send(vqh_pkg::REQ_CB_WRITE, 8'd255, 7'd127, 16'sh8000, 1'b0);
    send(vqh_pkg::REQ_DESC, 8'd0, 7'd0, 16'sd0, 1'b0);
    send(vqh_pkg::REQ_DESC, 8'd255, 7'd1, 16'sd0, 1'b1);
    // Only element 1 changes; center 0 is now closer by a hair.
    send(vqh_pkg::REQ_DESC, 8'd0, 7'd1, 16'sh8000, 1'b1);
    // An element past the vector length is stored but never searched, and a
    // last mark on such an element still starts the search.
    send(vqh_pkg::REQ_DESC, 8'd0, 7'd127, 16'sh7FFF, 1'b0);
    send(vqh_pkg::REQ_DESC, 8'd0, 7'd127, -16'sd1, 1'b1);
    send(vqh_pkg::REQ_BIN_READ, 8'd1, 7'd0, 16'sd0, 1'b0);
    send(vqh_pkg::REQ_BIN_READ, 8'd0, 7'd0, 16'sd0, 1'b0);
    send(vqh_pkg::REQ_CLEAR, 8'd0, 7'd0, 16'sd0, 1'b0);
    send(vqh_pkg::REQ_BIN_READ, 8'd0, 7'd0, 16'sd0, 1'b0);

    // Register extremes: the largest center count with one element, values
    // above the range that clamp to the maximum, zero that acts as one, and
    // the longest vector with few centers, sent with no idling on either side.
    set_config(16'd256, 16'd1);
    fill_codebook();
    copy_center();
    repeat (6) send_descriptor();
    set_config(16'hFFFF, 16'hFF00);
    repeat (4) send_descriptor();
    set_config(16'd0, 16'd255);
    fill_codebook();
    send_descriptor();
    set_config(16'd2, 16'd128);
    calm = 1'b1;
    fill_codebook();
    send_descriptor();
    calm = 1'b0;

    // Random part. Sizes stay small so searches are cheap; a few phases try a
    // zero register, many centers, or long vectors.
    start = beats_sent;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      nc = $urandom_range(1, 12);
      vl = $urandom_range(1, 8);
      if (phase == 3) nc = 0;
      if (phase == 5) vl = 0;
      if (phase == 7) begin
        nc = $urandom_range(40, 64);
        vl = $urandom_range(1, 4);
      end
      if (phase == 8) begin
        nc = $urandom_range(1, 3);
        vl = $urandom_range(60, 100);
      end
      set_config({7'($urandom), 9'(nc)}, {8'($urandom), 8'(vl)});
      fill_codebook();
      calm = (phase == 2);
      goal = start + (phase + 1) * RANDOM_BEATS / RANDOM_PHASES;
      while (beats_sent < goal) begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          send_descriptor();
        end else if (roll < 65) begin
          send(vqh_pkg::REQ_CB_WRITE, 8'($urandom_range(active_centers - 1)),
               7'($urandom_range(active_length - 1)), rand_value(), 1'($urandom));
        end else if (roll < 70) begin
          copy_center();
        end else if (roll < 80) begin
          send(vqh_pkg::REQ_BIN_READ, 8'($urandom), 7'($urandom), rand_value(),
               1'($urandom));
        end else if (roll < 83) begin
          send(vqh_pkg::REQ_CLEAR, 8'($urandom), 7'($urandom), rand_value(),
               1'($urandom));
        end else begin
          send_noise();
        end
      end
      calm = 1'b0;
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/vqh_pkg.sv
hw/rtl/vqh_in_if.sv
hw/rtl/vqh_out_if.sv
hw/rtl/vqh_cfg_if.sv
hw/rtl/vqh_dist_unit.sv
hw/rtl/nearest_codeword_histogram_top.sv
test/nearest_codeword_checker.sv
test/tb.sv
